// File: sv/snapshot_rle_decoder_assert.svh
`ifndef SNAPSHOT_RLE_DECODER_ASSERT_SVH
`define SNAPSHOT_RLE_DECODER_ASSERT_SVH

// Same-cycle implication, sampled at the rising edge of ck, off while off is high.
`define SRD_ASSERT_SAME(label, ck, off, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (off) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SRD_ASSERT_NEXT(label, ck, off, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (off) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/srd_pkg.sv
package srd_pkg;

  typedef enum logic [1:0] {
    KIND_WRITE    = 2'd0,
    KIND_DONE     = 2'd1,
    KIND_OVERFLOW = 2'd2,
    KIND_BAD_LEN  = 2'd3
  } kind_t;

  typedef enum logic {
    ST_RUN   = 1'b0,
    ST_FLUSH = 1'b1
  } state_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] start_address;
    logic [7:0]  fill_value;
    logic [7:0]  repeat_count;
    logic        last_of_item;
  } result_t;

  localparam logic       CFG_COMPRESSED   = 1'b0;
  localparam logic       CFG_LOAD_ADDRESS = 1'b1;

  localparam logic       RESET_COMPRESSED   = 1'b1;
  localparam logic [15:0] RESET_LOAD_ADDRESS = 16'h4000;

  localparam logic [7:0] ESC_BYTE  = 8'hED;
  localparam logic [7:0] END_BYTE  = 8'h00;
  localparam logic [7:0] MIN_RUN   = 8'h05;
  localparam logic [7:0] SHORT_RUN = 8'h02;

endpackage

// File: sv/srd_raw_if.sv
interface srd_raw_if import srd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

// File: sv/srd_run_if.sv
interface srd_run_if import srd_pkg::*; ();
  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [15:0] start_address;
  logic [7:0]  fill_value;
  logic [7:0]  repeat_count;
  logic        last_of_item;

  modport source (
    output valid, output kind, output start_address, output fill_value,
    output repeat_count, output last_of_item, input ready
  );
  modport sink (
    input valid, input kind, input start_address, input fill_value,
    input repeat_count, input last_of_item, output ready
  );
endinterface

// File: sv/snapshot_rle_decoder.sv
// Snapshot memory-image decoder: raw image bytes in on raw, memory-write runs and
// status results out on runs. A byte is decided when three more bytes sit behind it
// in a 3-byte lookahead window, so the first three bytes of a file give nothing yet.
// Results pass through a 4-entry queue; a request is taken only while the queue has
// room for two. A byte takes one cycle while raw is ready and yields at most one run,
// except a lone ED passed through, which yields two. A request with final_byte set
// starts a flush (one step per window byte still undecided, plus one for the end
// status) during which raw is not ready, unless a done or error status came first;
// the decoder then returns to its reset state with write address load_address.
// After a done or error status no results appear until the next final byte.
module snapshot_rle_decoder import srd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  srd_raw_if.sink     raw,
  srd_run_if.source   runs
);

  // configuration
  logic        compressed;
  logic [15:0] load_address;

  // decoder state
  logic [7:0]  win [4];
  logic [1:0]  fill;
  logic [2:0]  fcnt;
  logic [15:0] write_address;
  logic        escape_seen;
  logic        run_pending;
  logic [7:0]  run_length;
  logic        stopped;
  state_t      state, state_next;

  // result queue
  result_t     q [4];
  logic [1:0]  wptr, rptr;
  logic [2:0]  count;

  logic        room, accept, pop, do_clear;
  logic [1:0]  push_num;
  result_t     push0, push1;

  // decide unit
  logic        d_fire;
  logic [7:0]  d_b0, d_b1, d_b2, d_b3;
  logic [2:0]  d_cnt;
  logic        n1, n2, n3;
  result_t     d_res0, d_res1;
  logic [1:0]  d_num;
  logic [15:0] wa_d;
  logic        esc_d, rp_d, stop_d;
  logic [7:0]  rl_d;

  function automatic result_t mk_result(kind_t k, logic [15:0] a, logic [7:0] f,
                                        logic [7:0] c);
    result_t r;
    r.kind          = k;
    r.start_address = a;
    r.fill_value    = f;
    r.repeat_count  = c;
    r.last_of_item  = 1'b0;
    return r;
  endfunction

  assign room   = count <= 3'd2;
  assign accept = raw.valid && raw.ready;
  assign pop    = runs.valid && runs.ready;

  assign raw.ready          = (state == ST_RUN) && room;
  assign runs.valid         = count != 3'd0;
  assign runs.kind          = q[rptr].kind;
  assign runs.start_address = q[rptr].start_address;
  assign runs.fill_value    = q[rptr].fill_value;
  assign runs.repeat_count  = q[rptr].repeat_count;
  assign runs.last_of_item  = q[rptr].last_of_item;

  // In normal flow the window plus the new byte are decided at the oldest byte;
  // during flush the window shifts down and the count of valid bytes shrinks.
  always_comb begin
    if (state == ST_FLUSH) begin
      d_b0  = win[0];
      d_b1  = win[1];
      d_b2  = win[2];
      d_b3  = win[3];
      d_cnt = fcnt;
    end else begin
      d_b0  = win[0];
      d_b1  = win[1];
      d_b2  = win[2];
      d_b3  = raw.data_byte;
      d_cnt = 3'd4;
    end
  end

  assign n1 = d_cnt > 3'd1;
  assign n2 = d_cnt > 3'd2;
  assign n3 = d_cnt > 3'd3;

  always_comb begin
    d_res0 = mk_result(KIND_WRITE, write_address, 8'h00, 8'h00);
    d_res1 = mk_result(KIND_WRITE, write_address, 8'h00, 8'h00);
    d_num  = 2'd0;
    wa_d   = write_address;
    esc_d  = escape_seen;
    rp_d   = run_pending;
    rl_d   = run_length;
    stop_d = stopped;
    if (!stopped) begin
      if (d_b0 == END_BYTE && n1 && d_b1 == ESC_BYTE && n2 && d_b2 == ESC_BYTE && n3 &&
          d_b3 == END_BYTE) begin
        d_res0 = mk_result(KIND_DONE, write_address, 8'h00, 8'h00);
        d_num  = 2'd1;
        stop_d = 1'b1;
      end else if (write_address == 16'h0000) begin
        d_res0 = mk_result(KIND_OVERFLOW, write_address, 8'h00, 8'h00);
        d_num  = 2'd1;
        stop_d = 1'b1;
      end else if (run_pending) begin
        if (run_length != 8'h00) begin
          d_res0 = mk_result(KIND_WRITE, write_address, d_b0, run_length);
          d_num  = 2'd1;
          wa_d   = write_address + {8'h00, run_length};
          rp_d   = 1'b0;
          rl_d   = 8'h00;
        end else if (d_b0 < MIN_RUN && !(d_b0 == SHORT_RUN && n1 && d_b1 == ESC_BYTE)) begin
          d_res0 = mk_result(KIND_BAD_LEN, write_address, 8'h00, 8'h00);
          d_num  = 2'd1;
          stop_d = 1'b1;
        end else begin
          rl_d = d_b0;
        end
      end else if (escape_seen) begin
        esc_d = 1'b0;
        if (d_b0 == ESC_BYTE) begin
          rp_d = 1'b1;
        end else begin
          // lone ED: pass it and the byte after it through
          d_res0 = mk_result(KIND_WRITE, write_address, ESC_BYTE, 8'd1);
          d_res1 = mk_result(KIND_WRITE, write_address + 16'd1, d_b0, 8'd1);
          d_num  = 2'd2;
          wa_d   = write_address + 16'd2;
        end
      end else if (compressed && d_b0 == ESC_BYTE) begin
        esc_d = 1'b1;
      end else begin
        d_res0 = mk_result(KIND_WRITE, write_address, d_b0, 8'd1);
        d_num  = 2'd1;
        wa_d   = write_address + 16'd1;
      end
    end
    // during flush a status always ends the request; otherwise the last result does
    if (state == ST_FLUSH) begin
      d_res0.last_of_item = d_res0.kind != KIND_WRITE;
      d_res1.last_of_item = 1'b0;
    end else begin
      d_res0.last_of_item = d_num == 2'd1;
      d_res1.last_of_item = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    d_fire     = 1'b0;
    do_clear   = 1'b0;
    push_num   = 2'd0;
    push0      = d_res0;
    push1      = d_res1;
    case (state)
      ST_RUN: begin
        if (accept && raw.final_byte) begin
          if (stopped) begin
            do_clear = 1'b1;
          end else begin
            state_next = ST_FLUSH;
          end
        end else if (accept && fill == 2'd3) begin
          d_fire   = 1'b1;
          push_num = d_num;
        end
      end
      ST_FLUSH: begin
        if (room) begin
          if (fcnt != 3'd0) begin
            d_fire   = 1'b1;
            push_num = d_num;
            if (stop_d) begin
              do_clear   = 1'b1;
              state_next = ST_RUN;
            end
          end else begin
            push0              = mk_result(KIND_DONE, write_address, 8'h00, 8'h00);
            push0.last_of_item = 1'b1;
            push_num           = 2'd1;
            do_clear           = 1'b1;
            state_next         = ST_RUN;
          end
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      compressed    <= RESET_COMPRESSED;
      load_address  <= RESET_LOAD_ADDRESS;
      fill          <= 2'd0;
      fcnt          <= 3'd0;
      write_address <= RESET_LOAD_ADDRESS;
      escape_seen   <= 1'b0;
      run_pending   <= 1'b0;
      run_length    <= 8'h00;
      stopped       <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_COMPRESSED) begin
          compressed <= cfg_data[0];
        end else begin
          load_address <= cfg_data;
        end
      end
      // back to reset state after the final byte
      if (do_clear) begin
        fill          <= 2'd0;
        fcnt          <= 3'd0;
        write_address <= load_address;
        escape_seen   <= 1'b0;
        run_pending   <= 1'b0;
        run_length    <= 8'h00;
        stopped       <= 1'b0;
      end else begin
        if (d_fire) begin
          write_address <= wa_d;
          escape_seen   <= esc_d;
          run_pending   <= rp_d;
          run_length    <= rl_d;
          stopped       <= stop_d;
        end
        if (state == ST_FLUSH) begin
          if (d_fire) begin
            win[0] <= win[1];
            win[1] <= win[2];
            win[2] <= win[3];
            fcnt   <= fcnt - 3'd1;
          end
        end else if (accept) begin
          if (raw.final_byte) begin
            win[fill] <= raw.data_byte;
            fcnt      <= {1'b0, fill} + 3'd1;
          end else if (fill != 2'd3) begin
            win[fill] <= raw.data_byte;
            fill      <= fill + 2'd1;
          end else begin
            win[0] <= win[1];
            win[1] <= win[2];
            win[2] <= raw.data_byte;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_num != 2'd0) begin
      q[wptr] <= push0;
    end
    if (push_num == 2'd2) begin
      q[wptr + 2'd1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 2'd0;
      rptr  <= 2'd0;
      count <= 3'd0;
    end else begin
      wptr  <= wptr + push_num;
      rptr  <= rptr + {1'b0, pop};
      count <= count + {1'b0, push_num} - {2'b00, pop};
    end
  end

endmodule

// File: sv/srd_checker.sv
`include "snapshot_rle_decoder_assert.svh"

module srd_checker import srd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input kind_t       kind,
  input logic [15:0] start_address,
  input logic [7:0]  fill_value,
  input logic [7:0]  repeat_count,
  input logic        last_of_item
);

  // a stalled result holds
  `SRD_ASSERT_NEXT(a_hold, clk, rst, valid && !ready, valid && $stable(kind) && $stable(start_address) && $stable(fill_value) && $stable(repeat_count) && $stable(last_of_item), "stalled result changed")

  `SRD_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !valid, "result shown right after reset")

  `SRD_ASSERT_SAME(a_run_nonzero, clk, rst, valid && kind == KIND_WRITE, repeat_count != 8'd0, "write run with zero count")

  // a status ends output for its request
  `SRD_ASSERT_SAME(a_status_shape, clk, rst, valid && kind != KIND_WRITE, fill_value == 8'd0 && repeat_count == 8'd0 && last_of_item, "malformed status result")

endmodule

bind snapshot_rle_decoder srd_checker u_srd_checker (
  .clk           (clk),
  .rst           (rst),
  .valid         (runs.valid),
  .ready         (runs.ready),
  .kind          (runs.kind),
  .start_address (runs.start_address),
  .fill_value    (runs.fill_value),
  .repeat_count  (runs.repeat_count),
  .last_of_item  (runs.last_of_item)
);

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import srd_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int ITEM_TARGET   = 460;

  typedef enum {
    U_LITERAL, U_RUN, U_SHORT_RUN, U_LONE_ESC, U_NOISE, U_BAD_RUN, U_MARKER
  } unit_shape_t;

  // Image decoder model plus the queue of runs and status results still owed.
  class run_scoreboard;
    bit              compressed;
    logic [15:0]     load_address;
    logic [2:0][7:0] window;
    int              window_fill;
    logic [15:0]     write_address;
    bit              escape_seen;
    bit              run_pending;
    logic [7:0]      run_length;
    bit              halted;
    result_t         step_q[$];
    result_t         expected_q[$];
    int              errors;
    int              requests;
    int              writes_seen;
    int              status_seen;

    function new();
      compressed   = RESET_COMPRESSED;
      load_address = RESET_LOAD_ADDRESS;
      restart();
    endfunction

    function void restart();
      window        = '0;
      window_fill   = 0;
      write_address = load_address;
      escape_seen   = 1'b0;
      run_pending   = 1'b0;
      run_length    = '0;
      halted        = 1'b0;
    endfunction

    function void set_reg(logic idx, logic [15:0] value);
      if (idx == CFG_COMPRESSED) begin
        compressed = value[0];
      end else begin
        load_address = value;
      end
    endfunction

    function void emit(kind_t k, logic [15:0] addr, logic [7:0] value, logic [7:0] count);
      result_t r;
      r.kind          = k;
      r.start_address = addr;
      r.fill_value    = value;
      r.repeat_count  = count;
      r.last_of_item  = 1'b0;
      step_q.push_back(r);
    endfunction

    // Decide byte p of win, which holds cnt valid bytes; missing bytes match nothing.
    function void decide(logic [3:0][7:0] win, int p, int cnt);
      logic [7:0] v;
      bit         n1;
      bit         n2;
      bit         n3;
      v  = win[p];
      n1 = (p + 1 < cnt);
      n2 = (p + 2 < cnt);
      n3 = (p + 3 < cnt);
      if (halted) return;
      if (v == END_BYTE && n1 && win[p+1] == ESC_BYTE && n2 && win[p+2] == ESC_BYTE &&
          n3 && win[p+3] == END_BYTE) begin
        emit(KIND_DONE, write_address, '0, '0);
        halted = 1'b1;
        return;
      end
      if (write_address == 16'd0) begin
        emit(KIND_OVERFLOW, write_address, '0, '0);
        halted = 1'b1;
        return;
      end
      if (run_pending) begin
        if (run_length != 8'd0) begin
          emit(KIND_WRITE, write_address, v, run_length);
          write_address = write_address + 16'(run_length);
          run_pending   = 1'b0;
          run_length    = '0;
        end else if (v < MIN_RUN && !(v == SHORT_RUN && n1 && win[p+1] == ESC_BYTE)) begin
          emit(KIND_BAD_LEN, write_address, '0, '0);
          halted = 1'b1;
        end else begin
          run_length = v;
        end
      end else if (escape_seen) begin
        if (v == ESC_BYTE) begin
          run_pending = 1'b1;
        end else begin
          emit(KIND_WRITE, write_address, ESC_BYTE, 8'd1);
          write_address = write_address + 16'd1;
          emit(KIND_WRITE, write_address, v, 8'd1);
          write_address = write_address + 16'd1;
        end
        escape_seen = 1'b0;
      end else if (compressed && v == ESC_BYTE) begin
        escape_seen = 1'b1;
      end else begin
        emit(KIND_WRITE, write_address, v, 8'd1);
        write_address = write_address + 16'd1;
      end
    endfunction

    function void note_request(logic [7:0] value, bit fin);
      logic [3:0][7:0] win;
      int              cnt;
      int              i;
      win = '0;
      for (i = 0; i < window_fill; i++) win[i] = window[i];
      win[window_fill] = value;
      cnt = window_fill + 1;
      requests++;
      step_q.delete();
      if (fin) begin
        for (i = 0; i < cnt; i++) decide(win, i, cnt);
        if (!halted) emit(KIND_DONE, write_address, '0, '0);
        restart();
      end else if (cnt < 4) begin
        for (i = 0; i < cnt; i++) window[i] = win[i];
        window_fill = cnt;
      end else begin
        decide(win, 0, 4);
        window[0]   = win[1];
        window[1]   = win[2];
        window[2]   = win[3];
        window_fill = 3;
      end
      if (step_q.size() > 0) step_q[step_q.size() - 1].last_of_item = 1'b1;
      foreach (step_q[j]) expected_q.push_back(step_q[j]);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d addr %h fill %h count %0d",
                                  got.kind, got.start_address, got.fill_value,
                                  got.repeat_count));
        return;
      end
      want = expected_q.pop_front();
      if (want.kind == KIND_WRITE) writes_seen++;
      else status_seen++;
      if (got.kind !== want.kind || got.start_address !== want.start_address ||
          got.fill_value !== want.fill_value || got.repeat_count !== want.repeat_count ||
          got.last_of_item !== want.last_of_item) begin
        report_mismatch($sformatf(
          "got kind %0d addr %h fill %h count %0d last %b, want %0d %h %h %0d %b",
          got.kind, got.start_address, got.fill_value, got.repeat_count, got.last_of_item,
          want.kind, want.start_address, want.fill_value, want.repeat_count,
          want.last_of_item));
      end
    endtask
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = CFG_COMPRESSED;
  logic [15:0] cfg_data  = '0;

  srd_raw_if raw_bus ();
  srd_run_if run_bus ();

  run_scoreboard sb = new();

  bit send_quiet;
  bit recv_quiet;
  int stall_left;
  int cycle_count;
  int files_sent;
  int phases;

  snapshot_rle_decoder uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .raw       (raw_bus),
    .runs      (run_bus)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.expected_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    result_t got;
    if (rst) begin
      run_bus.ready <= 1'b0;
    end else begin
      if (run_bus.valid && run_bus.ready) begin
        got.kind          = run_bus.kind;
        got.start_address = run_bus.start_address;
        got.fill_value    = run_bus.fill_value;
        got.repeat_count  = run_bus.repeat_count;
        got.last_of_item  = run_bus.last_of_item;
        sb.check_result(got);
      end
      if (stall_left > 0) begin
        run_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        run_bus.ready <= 1'b1;
        if (!recv_quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  function automatic logic [7:0] literal_byte();
    logic [7:0] v;
    do v = 8'($urandom); while (sb.compressed && v == ESC_BYTE);
    return v;
  endfunction

  task automatic send_byte(input logic [7:0] value, input bit fin);
    int gap;
    gap = send_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      raw_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    raw_bus.valid      <= 1'b1;
    raw_bus.data_byte  <= value;
    raw_bus.final_byte <= fin;
    @(posedge clk);
    while (!raw_bus.ready) @(posedge clk);
    sb.note_request(value, fin);
  endtask

  // Hold the sender until every owed result is back, then let a flush settle.
  task automatic wait_idle();
    raw_bus.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input bit comp, input logic [15:0] addr);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_COMPRESSED;
    cfg_data  <= {15'd0, comp};
    @(posedge clk);
    sb.set_reg(CFG_COMPRESSED, {15'd0, comp});
    cfg_index <= CFG_LOAD_ADDRESS;
    cfg_data  <= addr;
    @(posedge clk);
    sb.set_reg(CFG_LOAD_ADDRESS, addr);
    cfg_we    <= 1'b0;
  endtask

  // fin goes on the last byte of the unit.
  task automatic send_unit(input unit_shape_t shape, input bit fin);
    logic [7:0] count;
    case (shape)
      U_LITERAL: send_byte(literal_byte(), fin);
      U_NOISE:   send_byte(8'($urandom), fin);
      U_RUN: begin
        if ($urandom_range(0, 3) == 0) count = 8'($urandom_range(MIN_RUN, 255));
        else count = 8'($urandom_range(MIN_RUN, 12));
        send_byte(ESC_BYTE, 1'b0);
        send_byte(ESC_BYTE, 1'b0);
        send_byte(count, 1'b0);
        send_byte(8'($urandom), fin);
      end
      U_SHORT_RUN: begin
        send_byte(ESC_BYTE, 1'b0);
        send_byte(ESC_BYTE, 1'b0);
        send_byte(SHORT_RUN, 1'b0);
        send_byte(ESC_BYTE, fin);
      end
      U_LONE_ESC: begin
        send_byte(ESC_BYTE, 1'b0);
        send_byte(literal_byte(), fin);
      end
      U_BAD_RUN: begin
        send_byte(ESC_BYTE, 1'b0);
        send_byte(ESC_BYTE, 1'b0);
        send_byte(8'($urandom_range(0, MIN_RUN - 1)), 1'b0);
        send_byte(literal_byte(), fin);
      end
      default: begin
        send_byte(END_BYTE, 1'b0);
        send_byte(ESC_BYTE, 1'b0);
        send_byte(ESC_BYTE, 1'b0);
        send_byte(END_BYTE, fin);
      end
    endcase
  endtask

  task automatic send_body(input int units, input bit broken);
    int          brk;
    int          i;
    int          r;
    unit_shape_t shape;
    brk = broken ? $urandom_range(0, units - 1) : -1;
    for (i = 0; i < units; i++) begin
      r = $urandom_range(0, 99);
      if (i == brk) shape = ($urandom_range(0, 1) != 0) ? U_BAD_RUN : U_MARKER;
      else if (r < 50) shape = U_LITERAL;
      else if (r < 70) shape = U_RUN;
      else if (r < 78) shape = U_SHORT_RUN;
      else if (r < 90) shape = U_LONE_ESC;
      else shape = U_NOISE;
      send_unit(shape, 1'b0);
    end
  endtask

  task automatic send_file(input int units, input bit broken);
    int r;
    send_body(units, broken);
    r = $urandom_range(0, 99);
    if (r < 40) begin
      send_unit(U_MARKER, 1'b1);
    end else if (r < 70) begin
      send_unit(U_LITERAL, 1'b1);
    end else if (r < 85) begin
      send_unit(U_NOISE, 1'b1);
    end else if (r < 93) begin
      send_byte(ESC_BYTE, 1'b1);
    end else begin
      // run header cut off by the end of the file
      send_byte(ESC_BYTE, 1'b0);
      send_byte(ESC_BYTE, 1'b0);
      send_byte(8'($urandom_range(MIN_RUN, 255)), 1'b1);
    end
    files_sent++;
  endtask

  initial begin
    int          nfiles;
    int          i;
    bit          comp;
    logic [15:0] addr;

    raw_bus.valid      = 1'b0;
    raw_bus.data_byte  = '0;
    raw_bus.final_byte = 1'b0;
    send_quiet         = 1'b0;
    recv_quiet         = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: literals, a run, a lone escape, a two-byte run of ED, end marker.
    send_byte(END_BYTE, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(ESC_BYTE, 1'b0);
    send_byte(ESC_BYTE, 1'b0);
    send_byte(MIN_RUN, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(ESC_BYTE, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(ESC_BYTE, 1'b0);
    send_byte(ESC_BYTE, 1'b0);
    send_byte(SHORT_RUN, 1'b0);
    send_byte(ESC_BYTE, 1'b0);
    send_byte(END_BYTE, 1'b0);
    send_byte(ESC_BYTE, 1'b0);
    send_byte(ESC_BYTE, 1'b0);
    send_byte(END_BYTE, 1'b1);
    wait_idle();

    // Verbatim copy at the top of memory: a one-byte file picks up the new load
    // address, then one write and the address wraps to 0.
    write_config(1'b0, 16'hFFFF);
    send_byte(8'h00, 1'b1);
    send_byte(8'h7F, 1'b0);
    send_byte(ESC_BYTE, 1'b0);
    send_byte(8'h01, 1'b1);
    wait_idle();

    // Short counts: one followed by a plain byte, one with nothing after it.
    write_config(1'b1, 16'h0001);
    send_byte(ESC_BYTE, 1'b0);
    send_byte(ESC_BYTE, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(ESC_BYTE, 1'b0);
    send_byte(ESC_BYTE, 1'b0);
    send_byte(SHORT_RUN, 1'b1);
    send_byte(ESC_BYTE, 1'b1);
    files_sent += 6;
    phases = 3;

    while (sb.requests < ITEM_TARGET) begin
      wait_idle();
      comp = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 5))
        0:       addr = 16'h0001;
        1:       addr = 16'hFFFF;
        2:       addr = RESET_LOAD_ADDRESS;
        3:       addr = 16'hFFF0;
        default: addr = 16'($urandom_range(1, 65535));
      endcase
      write_config(comp, addr);
      send_quiet = ($urandom_range(0, 4) == 0);
      recv_quiet = ($urandom_range(0, 4) == 0);
      nfiles = $urandom_range(1, 3);
      for (i = 0; i < nfiles; i++) begin
        send_file($urandom_range(2, 12), $urandom_range(0, 3) == 0);
      end
      // leave a file open across the next register write now and then
      if ($urandom_range(0, 6) == 0) send_body($urandom_range(1, 3), 1'b0);
      phases++;
    end

    send_byte(8'($urandom), 1'b1);
    raw_bus.valid <= 1'b0;
    for (i = 0; i < DRAIN_LIMIT && sb.expected_q.size() != 0; i++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.expected_q.size() != 0) begin
      sb.report_mismatch($sformatf("%0d expected results never arrived",
                                   sb.expected_q.size()));
    end

    $display("covered %0d image bytes in %0d files over %0d register settings",
             sb.requests, files_sent, phases);
    $display("checked %0d write runs and %0d status results, %0d mismatches",
             sb.writes_seen, sb.status_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/srd_pkg.sv
sv/srd_raw_if.sv
sv/srd_run_if.sv
sv/snapshot_rle_decoder.sv
sv/srd_checker.sv
dv/tb_top.sv
